>>> src/calu_pkg.sv
`default_nettype none

package calu_pkg;

   // Operation codes carried in the req_type field.
   typedef enum logic [4:0] {
      OP_ADD   = 5'd0,
      OP_ADC   = 5'd1,
      OP_SUB   = 5'd2,
      OP_SBC   = 5'd3,
      OP_AND   = 5'd4,
      OP_OR    = 5'd5,
      OP_XOR   = 5'd6,
      OP_CP    = 5'd7,
      OP_INC   = 5'd8,
      OP_DEC   = 5'd9,
      OP_RLC   = 5'd10,
      OP_RRC   = 5'd11,
      OP_RL    = 5'd12,
      OP_RR    = 5'd13,
      OP_SLA   = 5'd14,
      OP_SRA   = 5'd15,
      OP_SRL   = 5'd16,
      OP_SWAP  = 5'd17,
      OP_BIT   = 5'd18,
      OP_SET   = 5'd19,
      OP_RES   = 5'd20,
      OP_DAA   = 5'd21,
      OP_CPL   = 5'd22,
      OP_CCF   = 5'd23,
      OP_SCF   = 5'd24,
      OP_RLCA  = 5'd25,
      OP_RRCA  = 5'd26,
      OP_RLA   = 5'd27,
      OP_RRA   = 5'd28,
      OP_ADD16 = 5'd29,
      OP_ADDSP = 5'd30
   } op_type;

   // Decimal adjust constants.
   localparam logic [7:0] DAA_ADJ_HI   = 8'h60;
   localparam logic [7:0] DAA_ADJ_LO   = 8'h06;
   localparam logic [7:0] DAA_LIMIT_HI = 8'h99;
   localparam logic [3:0] DAA_LIMIT_LO = 4'h9;

   // Payload of one request transaction.
   typedef struct packed {
      logic [4:0]  req_type;
      logic [15:0] operand_a;
      logic [15:0] operand_b;
      logic [2:0]  bit_index;
      logic        zero_in;
      logic        subtract_in;
      logic        half_in;
      logic        carry_in;
   } req_payload_type;

   // Payload of one response transaction.
   typedef struct packed {
      logic [15:0] result;
      logic        zero_out;
      logic        subtract_out;
      logic        half_out;
      logic        carry_out;
   } rsp_payload_type;

endpackage

`default_nettype wire

>>> src/calu_ifs.sv
`default_nettype none

// Request channel: valid/ready handshake with the operation payload.
interface calu_req_if
   import calu_pkg::*;
   ;
   logic            valid;
   logic            ready;
   req_payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// Response channel: valid/ready handshake with the result and flags.
interface calu_rsp_if
   import calu_pkg::*;
   ;
   logic            valid;
   logic            ready;
   rsp_payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> src/calu_core.sv
`default_nettype none

module calu_core
   import calu_pkg::*;
(
   input  wire req_payload_type req,
   output rsp_payload_type      rsp
);

   op_type      op;
   logic [15:0] a16;
   logic [15:0] b16;
   logic [7:0]  a;
   logic [7:0]  b;
   logic        add_cin;
   logic        sub_cin;
   logic [8:0]  sum9;
   logic [4:0]  hsum;
   logic [8:0]  diff9;
   logic [4:0]  hdiff;
   logic [16:0] sum17;
   logic [12:0] hsum12;
   logic [15:0] offset16;
   logic [7:0]  bit_mask;
   logic        daa_hi;
   logic        daa_lo;
   logic [7:0]  daa_adj;
   logic [7:0]  r8;
   logic        is_byte;

   assign op  = op_type'(req.req_type);
   assign a16 = req.operand_a;
   assign b16 = req.operand_b;
   assign a   = a16[7:0];
   assign b   = b16[7:0];

   // Shared adders: byte add and subtract with their nibble carries.
   assign add_cin = (op == OP_ADC) & req.carry_in;
   assign sub_cin = (op == OP_SBC) & req.carry_in;
   assign sum9    = {1'b0, a} + {1'b0, b} + {8'h00, add_cin};
   assign hsum    = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'h0, add_cin};
   assign diff9   = {1'b0, a} - {1'b0, b} - {8'h00, sub_cin};
   assign hdiff   = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'h0, sub_cin};

   // Sixteen-bit adds: register pair add and stack pointer offset.
   assign sum17    = {1'b0, a16} + {1'b0, b16};
   assign hsum12   = {1'b0, a16[11:0]} + {1'b0, b16[11:0]};
   assign offset16 = {{8{b[7]}}, b};

   assign bit_mask = 8'h01 << req.bit_index;

   // Decimal adjust: correction chosen from the flags and the digits.
   assign daa_hi  = req.carry_in | (a > DAA_LIMIT_HI);
   assign daa_lo  = req.half_in | (a[3:0] > DAA_LIMIT_LO);
   assign daa_adj = req.subtract_in
                    ? ((req.carry_in ? DAA_ADJ_HI : 8'h00) | (req.half_in ? DAA_ADJ_LO : 8'h00))
                    : ((daa_hi ? DAA_ADJ_HI : 8'h00) | (daa_lo ? DAA_ADJ_LO : 8'h00));

   // Operation select. Flags default to the incoming ones, the result to
   // the first operand; byte operations zero the upper byte.
   always_comb begin
      r8               = a;
      is_byte          = 1'b1;
      rsp.result       = a16;
      rsp.zero_out     = req.zero_in;
      rsp.subtract_out = req.subtract_in;
      rsp.half_out     = req.half_in;
      rsp.carry_out    = req.carry_in;
      case (op)
         OP_ADD, OP_ADC: begin
            r8               = sum9[7:0];
            rsp.subtract_out = 1'b0;
            rsp.half_out     = hsum[4];
            rsp.carry_out    = sum9[8];
         end
         OP_SUB, OP_SBC, OP_CP: begin
            r8               = diff9[7:0];
            rsp.subtract_out = 1'b1;
            rsp.half_out     = hdiff[4];
            rsp.carry_out    = diff9[8];
         end
         OP_AND: begin
            r8               = a & b;
            rsp.subtract_out = 1'b0;
            rsp.half_out     = 1'b1;
            rsp.carry_out    = 1'b0;
         end
         OP_OR: begin
            r8               = a | b;
            rsp.subtract_out = 1'b0;
            rsp.half_out     = 1'b0;
            rsp.carry_out    = 1'b0;
         end
         OP_XOR: begin
            r8               = a ^ b;
            rsp.subtract_out = 1'b0;
            rsp.half_out     = 1'b0;
            rsp.carry_out    = 1'b0;
         end
         OP_INC: begin
            r8               = a + 8'd1;
            rsp.subtract_out = 1'b0;
            rsp.half_out     = (a[3:0] == 4'hf);
         end
         OP_DEC: begin
            r8               = a - 8'd1;
            rsp.subtract_out = 1'b1;
            rsp.half_out     = (a[3:0] == 4'h0);
         end
         OP_RLC, OP_RLCA: begin
            r8            = {a[6:0], a[7]};
            rsp.carry_out = a[7];
         end
         OP_RRC, OP_RRCA: begin
            r8            = {a[0], a[7:1]};
            rsp.carry_out = a[0];
         end
         OP_RL, OP_RLA: begin
            r8            = {a[6:0], req.carry_in};
            rsp.carry_out = a[7];
         end
         OP_RR, OP_RRA: begin
            r8            = {req.carry_in, a[7:1]};
            rsp.carry_out = a[0];
         end
         OP_SLA: begin
            r8            = {a[6:0], 1'b0};
            rsp.carry_out = a[7];
         end
         OP_SRA: begin
            r8            = {a[7], a[7:1]};
            rsp.carry_out = a[0];
         end
         OP_SRL: begin
            r8            = {1'b0, a[7:1]};
            rsp.carry_out = a[0];
         end
         OP_SWAP: begin
            r8               = {a[3:0], a[7:4]};
            rsp.subtract_out = 1'b0;
            rsp.half_out     = 1'b0;
            rsp.carry_out    = 1'b0;
         end
         OP_BIT: begin
            is_byte          = 1'b0;
            rsp.zero_out     = ~|(a & bit_mask);
            rsp.subtract_out = 1'b0;
            rsp.half_out     = 1'b1;
         end
         OP_SET: r8 = a | bit_mask;
         OP_RES: r8 = a & ~bit_mask;
         OP_DAA: begin
            r8            = req.subtract_in ? (a - daa_adj) : (a + daa_adj);
            rsp.half_out  = 1'b0;
            rsp.carry_out = req.subtract_in ? req.carry_in : daa_hi;
         end
         OP_CPL: begin
            r8               = ~a;
            rsp.subtract_out = 1'b1;
            rsp.half_out     = 1'b1;
         end
         OP_CCF: begin
            is_byte          = 1'b0;
            rsp.subtract_out = 1'b0;
            rsp.half_out     = 1'b0;
            rsp.carry_out    = ~req.carry_in;
         end
         OP_SCF: begin
            is_byte          = 1'b0;
            rsp.subtract_out = 1'b0;
            rsp.half_out     = 1'b0;
            rsp.carry_out    = 1'b1;
         end
         OP_ADD16: begin
            is_byte          = 1'b0;
            rsp.result       = sum17[15:0];
            rsp.subtract_out = 1'b0;
            rsp.half_out     = hsum12[12];
            rsp.carry_out    = sum17[16];
         end
         OP_ADDSP: begin
            is_byte          = 1'b0;
            rsp.result       = a16 + offset16;
            rsp.zero_out     = 1'b0;
            rsp.subtract_out = 1'b0;
            rsp.half_out     = hsum[4];
            rsp.carry_out    = sum9[8];
         end
         default: is_byte = 1'b0;
      endcase

      // Byte results and the zero flag of the byte operations.
      if (is_byte) begin
         rsp.result = {8'h00, r8};
      end
      case (op)
         OP_SET, OP_RES, OP_CPL: ;
         OP_RLCA, OP_RRCA, OP_RLA, OP_RRA: begin
            rsp.zero_out = 1'b0;
            rsp.subtract_out = 1'b0;
            rsp.half_out     = 1'b0;
         end
         OP_RLC, OP_RRC, OP_RL, OP_RR, OP_SLA, OP_SRA, OP_SRL: begin
            rsp.zero_out     = (r8 == 8'h00);
            rsp.subtract_out = 1'b0;
            rsp.half_out     = 1'b0;
         end
         default: begin
            if (is_byte) begin
               rsp.zero_out = (r8 == 8'h00);
            end
         end
      endcase

      // Compare keeps the first operand as its result.
      if (op == OP_CP) begin
         rsp.result = a16;
      end
   end

endmodule

`default_nettype wire

>>> src/cpu_alu_with_flags.sv
`default_nettype none

// Channel   Direction  Handshake      Payload
// req_chan  in         valid / ready  req_type, operand_a, operand_b, bit_index, flags in
// rsp_chan  out        valid / ready  result, zero_out, subtract_out, half_out, carry_out
//
// One transaction per cycle sustained while the response side is ready; each
// passes from the request register through the single ALU pass into the
// response register, from which it leaves on the response channel.
// Reset is synchronous and empties both registers; payloads are not reset.
// A stalled response holds; a request is still taken while the request
// register is empty or its contents can move into the response register.

module cpu_alu_with_flags
   import calu_pkg::*;
(
   input wire logic clock,
   input wire logic reset,
   calu_req_if.sink   req_chan,
   calu_rsp_if.source rsp_chan
);

   logic            req_valid_ff;
   logic            req_valid_in;
   req_payload_type req_data_ff;
   logic            rsp_valid_ff;
   logic            rsp_valid_in;
   rsp_payload_type rsp_data_ff;
   rsp_payload_type alu_rsp;
   logic            rsp_load;
   logic            req_load;

   // Response register loads whenever it is empty or being drained.
   assign rsp_load     = ~rsp_valid_ff | rsp_chan.ready;
   assign req_load     = ~req_valid_ff | rsp_load;
   assign req_chan.ready = req_load;
   assign req_valid_in = req_load ? req_chan.valid : req_valid_ff;
   assign rsp_valid_in = rsp_load ? req_valid_ff : rsp_valid_ff;

   // Request register.
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_load) begin
         req_data_ff <= req_chan.data;
      end
   end

   // Single pass through the ALU.
   calu_core u_core (
      .req (req_data_ff),
      .rsp (alu_rsp)
   );

   // Response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_data_ff <= alu_rsp;
      end
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.data  = rsp_data_ff;

endmodule

`default_nettype wire

>>> src/calu_checker.sv
`default_nettype none

module calu_checker
   import calu_pkg::*;
(
   input wire logic            clock,
   input wire logic            reset,
   input wire logic            req_valid,
   input wire logic            req_ready,
   input wire logic            rsp_valid,
   input wire logic            rsp_ready,
   input wire rsp_payload_type rsp_data
);

   // Reset leaves no response pending.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // A stalled response holds its value.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_data)))
      else $error("stalled response changed");

   // With no response pending the block always takes a request.
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request refused while response register empty");

   // An accepted transaction reaches the response when the output is not stalled.
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) ##1 rsp_ready |=> rsp_valid)
      else $error("accepted transaction did not reach the response");

endmodule

bind cpu_alu_with_flags calu_checker u_calu_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_chan.valid),
   .req_ready (req_chan.ready),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .rsp_data  (rsp_chan.data)
);

`default_nettype wire

>>> verif/testbench.sv
`timescale 1ns / 1ps

module testbench;
   import calu_pkg::*;

   // Code 31 has no operation behind it; the block passes operand and flags through.
   localparam logic [4:0] OP_UNUSED = 5'd31;

   localparam int unsigned RESET_CYCLES   = 10;
   localparam int unsigned HOLD_CYCLES    = 60;
   localparam int unsigned DRAIN_CYCLES   = 4;
   localparam int unsigned WATCHDOG_LIMIT = 2000;
   localparam int unsigned RANDOM_ITEMS   = 1600;
   localparam int unsigned CHUNK_ITEMS    = 100;

   logic clock;
   logic reset;

   calu_req_if req_chan ();
   calu_rsp_if rsp_chan ();

   cpu_alu_with_flags dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   rsp_payload_type pending_results[$];
   int unsigned     error_count;
   int unsigned     req_count;
   int unsigned     rsp_count;
   int unsigned     idle_cycles;
   logic [31:0]     ops_seen;
   bit              req_gaps_on;
   bit              rsp_stalls_on;
   bit              hold_request;

   // Free-running clock.
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Mostly back-to-back, now and then a short pause, rarely a long one.
   function automatic int unsigned pick_gap();
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 60) return 0;
      if (roll < 92) return $urandom_range(3, 1);
      return $urandom_range(40, 8);
   endfunction

   // Expected result and flags of one ALU operation.
   function automatic rsp_payload_type alu_predict(input req_payload_type q);
      logic [7:0]      a;
      logic [7:0]      b;
      logic [7:0]      r8;
      logic [8:0]      wide8;
      logic [4:0]      nib;
      logic [12:0]     wide12;
      logic [16:0]     wide16;
      logic            cin;
      logic            byte_result;
      logic            zero_from_r8;
      logic            shift_flags;
      rsp_payload_type p;
      a = q.operand_a[7:0];
      b = q.operand_b[7:0];
      r8 = a;
      cin = q.carry_in & ((q.req_type == OP_ADC) || (q.req_type == OP_SBC));
      byte_result = 1'b0;
      zero_from_r8 = 1'b0;
      shift_flags = 1'b0;
      p.result = q.operand_a;
      p.zero_out = q.zero_in;
      p.subtract_out = q.subtract_in;
      p.half_out = q.half_in;
      p.carry_out = q.carry_in;
      case (q.req_type)
         OP_ADD, OP_ADC: begin
            wide8 = {1'b0, a} + {1'b0, b} + {8'd0, cin};
            nib = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, cin};
            r8 = wide8[7:0];
            p.subtract_out = 1'b0;
            p.half_out = nib[4];
            p.carry_out = wide8[8];
            byte_result = 1'b1;
            zero_from_r8 = 1'b1;
         end
         OP_SUB, OP_SBC, OP_CP: begin
            p.half_out = {1'b0, a[3:0]} < ({1'b0, b[3:0]} + {4'd0, cin});
            p.carry_out = {1'b0, a} < ({1'b0, b} + {8'd0, cin});
            r8 = a - b - {7'd0, cin};
            p.subtract_out = 1'b1;
            byte_result = (q.req_type != OP_CP);
            zero_from_r8 = 1'b1;
         end
         OP_AND, OP_OR, OP_XOR: begin
            if (q.req_type == OP_AND) r8 = a & b;
            else if (q.req_type == OP_OR) r8 = a | b;
            else r8 = a ^ b;
            p.subtract_out = 1'b0;
            p.half_out = (q.req_type == OP_AND);
            p.carry_out = 1'b0;
            byte_result = 1'b1;
            zero_from_r8 = 1'b1;
         end
         OP_INC: begin
            r8 = a + 8'd1;
            p.half_out = (a[3:0] == 4'hf);
            p.subtract_out = 1'b0;
            byte_result = 1'b1;
            zero_from_r8 = 1'b1;
         end
         OP_DEC: begin
            r8 = a - 8'd1;
            p.half_out = (a[3:0] == 4'h0);
            p.subtract_out = 1'b1;
            byte_result = 1'b1;
            zero_from_r8 = 1'b1;
         end
         OP_RLC, OP_RLCA: begin
            p.carry_out = a[7];
            r8 = {a[6:0], a[7]};
            shift_flags = 1'b1;
         end
         OP_RRC, OP_RRCA: begin
            p.carry_out = a[0];
            r8 = {a[0], a[7:1]};
            shift_flags = 1'b1;
         end
         OP_RL, OP_RLA: begin
            p.carry_out = a[7];
            r8 = {a[6:0], q.carry_in};
            shift_flags = 1'b1;
         end
         OP_RR, OP_RRA: begin
            p.carry_out = a[0];
            r8 = {q.carry_in, a[7:1]};
            shift_flags = 1'b1;
         end
         OP_SLA: begin
            p.carry_out = a[7];
            r8 = {a[6:0], 1'b0};
            shift_flags = 1'b1;
         end
         OP_SRA: begin
            p.carry_out = a[0];
            r8 = {a[7], a[7:1]};
            shift_flags = 1'b1;
         end
         OP_SRL: begin
            p.carry_out = a[0];
            r8 = {1'b0, a[7:1]};
            shift_flags = 1'b1;
         end
         OP_SWAP: begin
            r8 = {a[3:0], a[7:4]};
            p.subtract_out = 1'b0;
            p.half_out = 1'b0;
            p.carry_out = 1'b0;
            byte_result = 1'b1;
            zero_from_r8 = 1'b1;
         end
         OP_BIT: begin
            p.zero_out = ~a[q.bit_index];
            p.subtract_out = 1'b0;
            p.half_out = 1'b1;
         end
         OP_SET: begin
            r8 = a | (8'd1 << q.bit_index);
            byte_result = 1'b1;
         end
         OP_RES: begin
            r8 = a & ~(8'd1 << q.bit_index);
            byte_result = 1'b1;
         end
         OP_DAA: begin
            if (q.subtract_in) begin
               if (q.carry_in) r8 = r8 - DAA_ADJ_HI;
               if (q.half_in) r8 = r8 - DAA_ADJ_LO;
            end else begin
               if (q.carry_in || (a > DAA_LIMIT_HI)) begin
                  r8 = r8 + DAA_ADJ_HI;
                  p.carry_out = 1'b1;
               end
               if (q.half_in || (a[3:0] > DAA_LIMIT_LO)) r8 = r8 + DAA_ADJ_LO;
            end
            p.half_out = 1'b0;
            byte_result = 1'b1;
            zero_from_r8 = 1'b1;
         end
         OP_CPL: begin
            r8 = ~a;
            p.subtract_out = 1'b1;
            p.half_out = 1'b1;
            byte_result = 1'b1;
         end
         OP_CCF, OP_SCF: begin
            p.subtract_out = 1'b0;
            p.half_out = 1'b0;
            p.carry_out = (q.req_type == OP_SCF) ? 1'b1 : ~q.carry_in;
         end
         OP_ADD16: begin
            wide16 = {1'b0, q.operand_a} + {1'b0, q.operand_b};
            wide12 = {1'b0, q.operand_a[11:0]} + {1'b0, q.operand_b[11:0]};
            p.result = wide16[15:0];
            p.subtract_out = 1'b0;
            p.half_out = wide12[12];
            p.carry_out = wide16[16];
         end
         OP_ADDSP: begin
            nib = {1'b0, a[3:0]} + {1'b0, b[3:0]};
            wide8 = {1'b0, a} + {1'b0, b};
            p.result = q.operand_a + {{8{b[7]}}, b};
            p.zero_out = 1'b0;
            p.subtract_out = 1'b0;
            p.half_out = nib[4];
            p.carry_out = wide8[8];
         end
         default: begin
         end
      endcase
      // Rotates and shifts share N and H clearing; only the CB forms derive Z.
      if (shift_flags) begin
         p.subtract_out = 1'b0;
         p.half_out = 1'b0;
         byte_result = 1'b1;
         zero_from_r8 = (q.req_type < OP_RLCA);
         if (q.req_type >= OP_RLCA) p.zero_out = 1'b0;
      end
      if (byte_result) p.result = {8'h00, r8};
      if (zero_from_r8) p.zero_out = (r8 == 8'h00);
      return p;
   endfunction

   task automatic check_field(input string name, input logic [15:0] expected,
                              input logic [15:0] actual);
      if (actual !== expected) begin
         $error("%s mismatch: expected 'h%0h, actual 'h%0h", name, expected, actual);
         error_count++;
      end
   endtask

   // Records each accepted request and checks each accepted response in order.
   always @(posedge clock) begin : result_checker
      rsp_payload_type want;
      if (!reset) begin
         if (req_chan.valid && req_chan.ready) begin
            pending_results.push_back(alu_predict(req_chan.data));
            ops_seen[req_chan.data.req_type] <= 1'b1;
            req_count++;
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            rsp_count++;
            if (pending_results.size() == 0) begin
               $error("response transaction arrived with no result expected");
               error_count++;
            end else begin
               want = pending_results.pop_front();
               check_field("result", want.result, rsp_chan.data.result);
               check_field("zero_out", 16'(want.zero_out), 16'(rsp_chan.data.zero_out));
               check_field("subtract_out", 16'(want.subtract_out),
                           16'(rsp_chan.data.subtract_out));
               check_field("half_out", 16'(want.half_out), 16'(rsp_chan.data.half_out));
               check_field("carry_out", 16'(want.carry_out), 16'(rsp_chan.data.carry_out));
            end
         end
      end
      if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
   end

   // Response side: random stalls, plus one long hold-off on request.
   initial begin : response_ready
      int unsigned stall_len;
      rsp_chan.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_request) begin
            stall_len = HOLD_CYCLES;
            hold_request = 1'b0;
         end else begin
            stall_len = rsp_stalls_on ? pick_gap() : 0;
         end
         if (stall_len > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (stall_len) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         @(posedge clock);
      end
   end

   // Ends the run if the channels go quiet for too long.
   initial begin : watchdog
      wait (idle_cycles >= WATCHDOG_LIMIT);
      $display("cpu_alu_with_flags regression: fail");
      $finish;
   end

   // Offers one request transaction and waits for it to be taken.
   task automatic send_op(input req_payload_type item);
      int unsigned gap;
      req_chan.valid <= 1'b1;
      req_chan.data <= item;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      gap = req_gaps_on ? pick_gap() : 0;
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_fields(input logic [4:0] op, input logic [15:0] a,
                              input logic [15:0] b, input logic [2:0] idx,
                              input logic [3:0] znhc);
      req_payload_type item;
      item.req_type = op;
      item.operand_a = a;
      item.operand_b = b;
      item.bit_index = idx;
      {item.zero_in, item.subtract_in, item.half_in, item.carry_in} = znhc;
      send_op(item);
   endtask

   // Sender pauses here until every outstanding result has come back.
   task automatic wait_for_drain();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   // One transaction per operation code, each aimed at its typical edge case.
   task automatic test_opcode_sweep();
      send_fields(OP_ADD,   16'hff0f, 16'h0001, 3'd0, 4'b0000);
      send_fields(OP_ADC,   16'h00ff, 16'hff00, 3'd7, 4'b1111);
      send_fields(OP_SUB,   16'h0000, 16'h0001, 3'd0, 4'b0000);
      send_fields(OP_SBC,   16'h0010, 16'h000f, 3'd0, 4'b0001);
      send_fields(OP_AND,   16'hffff, 16'h0000, 3'd0, 4'b1111);
      send_fields(OP_OR,    16'h0000, 16'h0000, 3'd0, 4'b1111);
      send_fields(OP_XOR,   16'hffff, 16'hffff, 3'd0, 4'b1111);
      send_fields(OP_CP,    16'hab12, 16'h0012, 3'd0, 4'b0000);
      send_fields(OP_INC,   16'h00ff, 16'h0000, 3'd0, 4'b0101);
      send_fields(OP_DEC,   16'h0001, 16'h0000, 3'd0, 4'b0001);
      send_fields(OP_RLC,   16'h0080, 16'h0000, 3'd0, 4'b0110);
      send_fields(OP_RRC,   16'h0001, 16'h0000, 3'd0, 4'b0110);
      send_fields(OP_RL,    16'h0080, 16'h0000, 3'd0, 4'b0000);
      send_fields(OP_RR,    16'h0001, 16'h0000, 3'd0, 4'b0001);
      send_fields(OP_SLA,   16'h0080, 16'h0000, 3'd0, 4'b0000);
      send_fields(OP_SRA,   16'h0081, 16'h0000, 3'd0, 4'b0000);
      send_fields(OP_SRL,   16'h0001, 16'h0000, 3'd0, 4'b0000);
      send_fields(OP_SWAP,  16'h00f0, 16'h0000, 3'd0, 4'b0111);
      send_fields(OP_BIT,   16'h807f, 16'h0000, 3'd7, 4'b0110);
      send_fields(OP_SET,   16'hff00, 16'h0000, 3'd7, 4'b1010);
      send_fields(OP_RES,   16'h00ff, 16'h0000, 3'd0, 4'b0101);
      send_fields(OP_DAA,   16'h009a, 16'h0000, 3'd0, 4'b0000);
      send_fields(OP_CPL,   16'h00ff, 16'h0000, 3'd0, 4'b1000);
      send_fields(OP_CCF,   16'hffff, 16'h0000, 3'd0, 4'b1111);
      send_fields(OP_SCF,   16'h1234, 16'h0000, 3'd0, 4'b0110);
      send_fields(OP_RLCA,  16'h0000, 16'h0000, 3'd0, 4'b1000);
      send_fields(OP_RRCA,  16'h0001, 16'h0000, 3'd0, 4'b0000);
      send_fields(OP_RLA,   16'h0080, 16'h0000, 3'd0, 4'b0000);
      send_fields(OP_RRA,   16'h0001, 16'h0000, 3'd0, 4'b1000);
      send_fields(OP_ADD16, 16'h0fff, 16'h0001, 3'd0, 4'b1111);
      send_fields(OP_ADDSP, 16'h00ff, 16'h0080, 3'd0, 4'b1100);
      send_fields(OP_UNUSED, 16'hbeef, 16'hffff, 3'd5, 4'b1010);
   endtask

   // Wrap-around at the 16-bit adds and decimal adjust after a subtraction.
   task automatic test_wide_and_decimal();
      send_fields(OP_ADD16, 16'hffff, 16'hffff, 3'd0, 4'b0000);
      send_fields(OP_ADDSP, 16'h0000, 16'h00ff, 3'd0, 4'b0000);
      send_fields(OP_DAA,   16'h0066, 16'h0000, 3'd0, 4'b0111);
   endtask

   // The response side stops for a long while as requests keep coming.
   task automatic test_output_stall();
      req_gaps_on = 1'b0;
      hold_request = 1'b1;
      for (int i = 0; i < 12; i++)
         send_fields(5'($urandom_range(30)), 16'($urandom), 16'($urandom),
                     3'($urandom_range(7)), 4'($urandom_range(15)));
   endtask

   function automatic logic [15:0] pick_operand();
      case ($urandom_range(11))
         0: return 16'h0000;
         1: return 16'hffff;
         2: return 16'h00ff;
         3: return 16'h0fff;
         4: return 16'h000f;
         5: return {8'($urandom), 8'h80};
         6: return {8'($urandom), 8'h99};
         7: return {8'h00, 8'($urandom)};
         default: return 16'($urandom);
      endcase
   endfunction

   // Random operations in chunks, each chunk with its own idling mix.
   task automatic test_random_ops();
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if ((i % CHUNK_ITEMS) == 0) begin
            req_gaps_on = ($urandom_range(3) != 0);
            rsp_stalls_on = ($urandom_range(3) != 0);
         end
         send_fields(5'($urandom_range(31)), pick_operand(), pick_operand(),
                     3'($urandom_range(7)), 4'($urandom_range(15)));
      end
   endtask

   initial begin
      reset <= 1'b1;
      req_chan.valid <= 1'b0;
      req_chan.data <= '0;
      error_count = 0;
      req_count = 0;
      rsp_count = 0;
      idle_cycles = 0;
      ops_seen = '0;
      req_gaps_on = 1'b1;
      rsp_stalls_on = 1'b1;
      hold_request = 1'b0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_opcode_sweep();
      test_wide_and_decimal();
      wait_for_drain();
      test_output_stall();
      wait_for_drain();
      test_random_ops();
      wait_for_drain();
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (pending_results.size() != 0) begin
         $error("%0d expected results never arrived", pending_results.size());
         error_count++;
      end
      $display("Checked %0d requests and %0d responses across %0d operation codes.",
               req_count, rsp_count, $countones(ops_seen));
      $display("Included flag corner cases, a long output hold-off and random idling.");
      if (error_count == 0)
         $display("cpu_alu_with_flags regression: pass");
      else
         $display("cpu_alu_with_flags regression: fail");
      $finish;
   end

endmodule
